/* src/sqfsk_pkg.sv */
// ----------------------------------------------------------------------------
// sqfsk_pkg
// Shared types and constants for the square-wave FSK byte modulator.
// ----------------------------------------------------------------------------
package sqfsk_pkg;

	// Item command codes.
	typedef enum logic {
		CMD_LOAD = 1'b0,
		CMD_TICK = 1'b1
	} cmd_e_t;

	// Configuration register indexes.
	localparam logic [1:0] REG_ONE_HALF  = 2'd0;
	localparam logic [1:0] REG_ZERO_HALF = 2'd1;
	localparam logic [1:0] REG_BIT_LEN   = 2'd2;

	// Configuration reset values.
	localparam logic [7:0] ONE_HALF_RESET  = 8'd15;
	localparam logic [7:0] ZERO_HALF_RESET = 8'd20;
	localparam logic [7:0] BIT_LEN_RESET   = 8'd120;

	// Level at the start of every bit, and the sign bit that each flip toggles.
	localparam logic [15:0] LEVEL_START = 16'h3FFF;
	localparam logic [15:0] SIGN_FLIP   = 16'h8000;

	// One classified item as it travels through the queue.
	typedef struct packed {
		cmd_e_t     cmd;
		logic [7:0] data;
	} item_t;

	// Head of the queue as seen by the back end.
	typedef struct packed {
		logic  valid;
		item_t item;
	} q_head_t;

	// Timing configuration.
	typedef struct packed {
		logic [7:0] one_half;
		logic [7:0] zero_half;
		logic [7:0] bit_len;
	} cfg_t;

endpackage

/* src/sqfsk_front.sv */
// ----------------------------------------------------------------------------
// sqfsk_front
// Accepts input items, tags each as a load or a tick, and queues them in order.
// ----------------------------------------------------------------------------
module sqfsk_front #(
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic             cmd,
	input  logic [7:0]       data_byte,
	output sqfsk_pkg::q_head_t head,
	input  logic             pop
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	sqfsk_pkg::item_t  slots_q [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  count_q;
	logic              push;
	sqfsk_pkg::item_t  new_item;

	// Classify the incoming item.
	always_comb begin
		new_item.cmd  = cmd ? sqfsk_pkg::CMD_TICK : sqfsk_pkg::CMD_LOAD;
		new_item.data = data_byte;
	end

	assign in_ready   = (count_q != CNT_W'(DEPTH));
	assign push       = in_valid && in_ready;
	assign head.valid = (count_q != '0);
	assign head.item  = slots_q[rd_ptr_q];

	// Queue storage.
	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= new_item;
		end
	end

	// Queue pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	// The back end only takes an item that is really queued.
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> (count_q != '0))
		else $error("queue popped while empty");

	// The fill count rises by one on a push without a pop.
	a_count_track: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> (count_q == $past(count_q) + 1'b1))
		else $error("queue count did not follow a push");

endmodule

/* src/sqfsk_back.sv */
// ----------------------------------------------------------------------------
// sqfsk_back
// Carries out queued items: loads fill the holding register, ticks step the
// bit and flip counters and produce one sample into the output register.
// ----------------------------------------------------------------------------
module sqfsk_back (
	input  logic               clk,
	input  logic               arst_n,
	input  sqfsk_pkg::q_head_t head,
	output logic               pop,
	input  sqfsk_pkg::cfg_t    cfg,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [15:0] sample,
	output logic               byte_done,
	output logic               holding_free
);

	logic [7:0]  active_byte_q;
	logic        active_valid_q;
	logic [7:0]  waiting_byte_q;
	logic        waiting_valid_q;
	logic [2:0]  bit_pos_q;
	logic [7:0]  tick_q;
	logic [7:0]  flip_q;
	logic [15:0] level_q;
	logic        out_valid_q;
	logic [15:0] sample_q;
	logic        done_q;
	logic        free_q;

	logic        is_tick;
	logic        slot_free;
	logic        tick_go;
	logic        load_go;
	logic        promote_start;
	logic        promote_end;
	logic        eff_valid;
	logic [7:0]  eff_byte;
	logic [2:0]  eff_pos;
	logic [7:0]  eff_tick;
	logic [7:0]  eff_flip;
	logic        cur_bit;
	logic [7:0]  half;
	logic [15:0] lvl_base;
	logic [15:0] lvl_out;
	logic [8:0]  flip_inc;
	logic [8:0]  tick_inc;
	logic        flip_wrap;
	logic        bit_end;
	logic        byte_end;
	logic        waiting_after;

	// Pop control: a load never needs the output slot, a tick does.
	assign is_tick   = (head.item.cmd == sqfsk_pkg::CMD_TICK);
	assign slot_free = !out_valid_q || out_ready;
	assign pop       = head.valid && (!is_tick || slot_free);
	assign tick_go   = pop && is_tick;
	assign load_go   = pop && !is_tick;

	// Byte selection, including promotion of a waiting byte when idle.
	always_comb begin
		promote_start = !active_valid_q && waiting_valid_q;
		eff_valid     = active_valid_q || waiting_valid_q;
		eff_byte      = promote_start ? waiting_byte_q : active_byte_q;
		eff_pos       = promote_start ? 3'd0 : bit_pos_q;
		eff_tick      = promote_start ? 8'd0 : tick_q;
		eff_flip      = promote_start ? 8'd0 : flip_q;
		cur_bit       = eff_byte[eff_pos];
		half          = cur_bit ? cfg.one_half : cfg.zero_half;
	end

	// Level generation and counter limits.
	always_comb begin
		lvl_base      = (eff_tick == 8'd0) ? sqfsk_pkg::LEVEL_START : level_q;
		lvl_out       = (eff_flip == 8'd0) ? (lvl_base ^ sqfsk_pkg::SIGN_FLIP) : lvl_base;
		flip_inc      = {1'b0, eff_flip} + 9'd1;
		tick_inc      = {1'b0, eff_tick} + 9'd1;
		flip_wrap     = (flip_inc >= {1'b0, half});
		bit_end       = (tick_inc >= {1'b0, cfg.bit_len});
		byte_end      = bit_end && (eff_pos == 3'd7);
		promote_end   = byte_end && waiting_valid_q && !promote_start;
		waiting_after = waiting_valid_q && !promote_start && !promote_end;
	end

	// Modulator state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_byte_q   <= '0;
			active_valid_q  <= 1'b0;
			waiting_byte_q  <= '0;
			waiting_valid_q <= 1'b0;
			bit_pos_q       <= '0;
			tick_q          <= '0;
			flip_q          <= '0;
			level_q         <= sqfsk_pkg::LEVEL_START;
		end else if (load_go) begin
			waiting_byte_q  <= head.item.data;
			waiting_valid_q <= 1'b1;
		end else if (tick_go && eff_valid) begin
			level_q         <= lvl_out;
			waiting_valid_q <= waiting_after;
			if (bit_end) begin
				tick_q <= '0;
				flip_q <= '0;
				if (byte_end) begin
					bit_pos_q      <= '0;
					active_valid_q <= promote_end;
					active_byte_q  <= promote_end ? waiting_byte_q : eff_byte;
				end else begin
					bit_pos_q      <= eff_pos + 3'd1;
					active_valid_q <= 1'b1;
					active_byte_q  <= eff_byte;
				end
			end else begin
				tick_q         <= tick_inc[7:0];
				flip_q         <= flip_wrap ? 8'd0 : flip_inc[7:0];
				bit_pos_q      <= eff_pos;
				active_valid_q <= 1'b1;
				active_byte_q  <= eff_byte;
			end
		end
	end

	// Output register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (tick_go) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if (tick_go) begin
			sample_q <= eff_valid ? lvl_out : 16'd0;
			done_q   <= eff_valid && byte_end;
			free_q   <= !waiting_after;
		end
	end

	assign out_valid    = out_valid_q;
	assign sample       = sample_q;
	assign byte_done    = done_q;
	assign holding_free = free_q;

	// A tick never overwrites a result that is still held.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		tick_go |-> slot_free)
		else $error("tick result overwrote a held item");

	// A byte only becomes active by promotion of a waiting byte.
	a_promote_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(active_valid_q) |-> $past(waiting_valid_q))
		else $error("byte became active with nothing waiting");

	// A byte ending with another waiting keeps the transmitter busy.
	a_back_to_back: assert property (@(posedge clk) disable iff (!arst_n)
		(tick_go && byte_end && active_valid_q && waiting_valid_q) |=>
		(active_valid_q && !waiting_valid_q))
		else $error("waiting byte not promoted at end of byte");

endmodule

/* src/square_wave_fsk_byte_modulator.sv */
// ----------------------------------------------------------------------------
// square_wave_fsk_byte_modulator
// Square-wave FSK modulator: bytes go out LSB first as 16-bit samples.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries cmd and data_byte. cmd = 0 loads
//   data_byte into the one-deep holding register (replacing any waiting byte)
//   and yields no result. cmd = 1 is a sample tick and yields exactly one
//   result item on the output channel (out_valid/out_ready): sample,
//   byte_done and holding_free.
//   Items enter a queue of QUEUE_DEPTH entries; the back end takes one item
//   per cycle from it while out_ready is high, so the sustained rate is then
//   one item per clock. A tick's result passes through the queue entry,
//   written when the item is accepted, and then the output register.
//   When the receiver stalls, the held result stays in the output register,
//   loads ahead of the first tick keep draining, and that tick and the items
//   behind it wait in the queue; in_ready drops once the queue is full. The
//   user must write timing registers (cfg_we/cfg_index/cfg_wdata) only while
//   idle; the block does not enforce it. Reset restores the default timing
//   (15, 20, 120), empties queue and holding register; the block starts silent.
// ----------------------------------------------------------------------------
module square_wave_fsk_byte_modulator #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               cmd,
	input  logic [7:0]         data_byte,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [15:0] sample,
	output logic               byte_done,
	output logic               holding_free,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_index,
	input  logic [7:0]         cfg_wdata
);

	sqfsk_pkg::cfg_t    cfg_q;
	sqfsk_pkg::q_head_t head;
	logic               pop;

	// Timing configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.one_half  <= sqfsk_pkg::ONE_HALF_RESET;
			cfg_q.zero_half <= sqfsk_pkg::ZERO_HALF_RESET;
			cfg_q.bit_len   <= sqfsk_pkg::BIT_LEN_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				sqfsk_pkg::REG_ONE_HALF:  cfg_q.one_half  <= cfg_wdata;
				sqfsk_pkg::REG_ZERO_HALF: cfg_q.zero_half <= cfg_wdata;
				sqfsk_pkg::REG_BIT_LEN:   cfg_q.bit_len   <= cfg_wdata;
				default:                  cfg_q           <= cfg_q;
			endcase
		end
	end

	// Front end: accept, classify and queue.
	sqfsk_front #(
		.DEPTH (QUEUE_DEPTH)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.cmd       (cmd),
		.data_byte (data_byte),
		.head      (head),
		.pop       (pop)
	);

	// Back end: modulator and output register.
	sqfsk_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head         (head),
		.pop          (pop),
		.cfg          (cfg_q),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.sample       (sample),
		.byte_done    (byte_done),
		.holding_free (holding_free)
	);

endmodule
